// File: src/sata_pkg.sv
// ----------------------------------------------------------------------------
// sata_pkg: shared constants of the set-associative tag directory
// Field widths of the access and result streams and the access kind codes.
// ----------------------------------------------------------------------------
package sata_pkg;

   localparam int ADDR_W    = 32;
   localparam int CYC_W     = 2;
   localparam int WAY_OUT_W = 2;

   // Stream widths in bits, padded to whole bytes: address and cycle bits packed, then the way.
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;

   // Access kinds carried on the request tuser bit.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

endpackage

// File: src/set_assoc_tag_access.sv
// ----------------------------------------------------------------------------
// set_assoc_tag_access: tag directory of a set-associative cache
// Looks up one access per cycle while results are taken, reports hit and way,
// and on a miss refills a way taken from the cycle bits or, in the last refilled set, the mirror of the last way.
// ----------------------------------------------------------------------------
// Usage. An access arrives on the req_ channel: tdata carries the byte
// address and the low cycle-count bits, tuser says read or write. Each
// access gives exactly one transfer on the rsp_ channel: tuser is the hit
// flag, tdata the way that hit or the way that was refilled.
// The transfer edge registers the access and reads the set's tag row from
// memory; the next edge at which the output register is free compares all
// ways in parallel, updates the directory, registers the result and raises
// rsp_tvalid. While results are taken, one access per cycle is sustained; the
// single read port of the tag memory, read once per access, sets that figure.
// When the receiver stalls, the result stays in the output register and one
// more access may sit in the lookup stage; after that req_tready falls.
// Reset clears all valid and dirty bits, the last-refill record and sets
// dirty tracking on; the tag memory needs no clearing since every way is
// invalid. A write on the csr_ channel (bit 0) switches dirty tracking; it
// must be made only while the block is idle, which the block does not enforce.
// NUM_SETS and BLOCK_BYTES must be powers of two; the block does not check it.
// ----------------------------------------------------------------------------
module set_assoc_tag_access #(
   parameter int ASSOC       = 4,
   parameter int NUM_SETS    = 64,
   parameter int BLOCK_BYTES = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: address [31:0], cycle_low [33:32], zero fill up to bit 39.
   input  logic [sata_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: operation (0 read, 1 write).
   input  logic                             req_tuser,
   // Result channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: way [1:0], zero fill up to bit 7.
   output logic [sata_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // tuser: hit.
   output logic                             rsp_tuser,
   // Configuration channel: track_dirty in bit 0.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_data
);

   localparam int OFF_W    = $clog2(BLOCK_BYTES);
   localparam int SET_BITS = $clog2(NUM_SETS);
   localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int TAG_W    = sata_pkg::ADDR_W - OFF_W - SET_BITS;
   localparam int WAY_W    = (ASSOC > 1) ? $clog2(ASSOC) : 1;
   localparam int ROW_W    = ASSOC * TAG_W;
   localparam logic [3:0] ASSOC_V = 4'(ASSOC);

   // ------------------------------------------------------------------
   // Request decode
   // ------------------------------------------------------------------
   logic [sata_pkg::ADDR_W-1:0] req_addr;
   logic [SET_W-1:0]            req_set;
   logic [TAG_W-1:0]            req_tag;
   logic                        req_fire;

   assign req_addr = req_tdata[sata_pkg::ADDR_W-1:0];
   assign req_tag  = req_addr[sata_pkg::ADDR_W-1 -: TAG_W];

   generate
      if (SET_BITS > 0) begin : g_set
         assign req_set = req_addr[OFF_W +: SET_W];
      end else begin : g_noset
         assign req_set = 1'b0;
      end
   endgenerate

   // ------------------------------------------------------------------
   // Lookup stage registers
   // ------------------------------------------------------------------
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_op_ff;
   logic [SET_W-1:0]      s1_set_ff;
   logic [TAG_W-1:0]      s1_tag_ff;
   logic [sata_pkg::CYC_W-1:0] s1_cyc_ff;
   // Forwarded row when the previous access refilled the same set at the
   // very edge that this access read the memory.
   logic                  fwd_ff, fwd_in;
   logic [ROW_W-1:0]      fwd_row_ff;

   // Directory state.
   logic [ASSOC-1:0]      valid_ff [NUM_SETS];
   logic [ASSOC-1:0]      dirty_ff [NUM_SETS];
   logic [SET_W-1:0]      last_set_ff;
   logic [WAY_W-1:0]      last_way_ff;
   logic                  refill_seen_ff;
   logic                  track_dirty_ff;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff;
   logic [sata_pkg::WAY_OUT_W-1:0] rsp_way_ff;

   logic                  out_free;
   logic                  s1_fire;
   logic                  is_write;
   logic                  mark_dirty;
   logic [ROW_W-1:0]      rd_row;
   logic [ROW_W-1:0]      eff_row;
   logic [ROW_W-1:0]      wr_row;
   logic [ASSOC-1:0]      match;
   logic                  hit;
   logic [WAY_W-1:0]      hit_way;
   logic [3:0]            rnd;
   logic                  same_set;
   logic [WAY_W-1:0]      victim;
   logic [WAY_W-1:0]      sel_way;
   logic [3:0]            sel_way_ext;

   // The lookup stage moves on when the output register is empty or being
   // emptied, so a result the receiver is taking does not block the next access.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   sata_tag_ram #(
      .DEPTH (NUM_SETS),
      .WIDTH (ROW_W)
   ) u_tag_ram (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (req_set),
      .rd_data (rd_row),
      .wr_en   (s1_fire && !hit),
      .wr_addr (s1_set_ff),
      .wr_data (wr_row)
   );

   // ------------------------------------------------------------------
   // Compare and victim choice
   // ------------------------------------------------------------------
   assign eff_row    = fwd_ff ? fwd_row_ff : rd_row;
   assign is_write   = (s1_op_ff == sata_pkg::OP_WRITE);
   assign mark_dirty = is_write && track_dirty_ff;

   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int w = 0; w < ASSOC; w++) begin
         match[w] = valid_ff[s1_set_ff][w] && (eff_row[w*TAG_W +: TAG_W] == s1_tag_ff);
      end
      // Scan downwards so that the lowest matching way wins.
      for (int w = ASSOC - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
   end

   // The cycle bits reduced modulo the associativity; at most three steps
   // are needed for a two-bit value.
   always_comb begin
      rnd = {2'b00, s1_cyc_ff};
      for (int k = 0; k < 3; k++) begin
         if (rnd >= ASSOC_V) begin
            rnd = rnd - ASSOC_V;
         end
      end
   end

   assign same_set = refill_seen_ff && (s1_set_ff == last_set_ff);
   assign victim   = same_set ? (WAY_W'(ASSOC - 1) - last_way_ff) : rnd[WAY_W-1:0];
   assign sel_way  = hit ? hit_way : victim;
   assign sel_way_ext = 4'(sel_way);

   always_comb begin
      wr_row = eff_row;
      wr_row[victim*TAG_W +: TAG_W] = s1_tag_ff;
   end

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_fire ? 1'b1 : ((rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff);
   assign fwd_in       = s1_fire && !hit && (req_set == s1_set_ff);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         fwd_ff         <= 1'b0;
         valid_ff       <= '{default: '0};
         dirty_ff       <= '{default: '0};
         last_set_ff    <= '0;
         last_way_ff    <= '0;
         refill_seen_ff <= 1'b0;
         track_dirty_ff <= 1'b1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            fwd_ff <= fwd_in;
         end
         if (csr_valid && csr_ready) begin
            track_dirty_ff <= csr_data;
         end
         if (s1_fire) begin
            if (hit) begin
               if (mark_dirty) begin
                  dirty_ff[s1_set_ff][hit_way] <= 1'b1;
               end
            end else begin
               valid_ff[s1_set_ff][victim] <= 1'b1;
               dirty_ff[s1_set_ff][victim] <= mark_dirty;
               last_set_ff    <= s1_set_ff;
               last_way_ff    <= victim;
               refill_seen_ff <= 1'b1;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff   <= req_tuser;
         s1_set_ff  <= req_set;
         s1_tag_ff  <= req_tag;
         s1_cyc_ff  <= req_tdata[sata_pkg::ADDR_W +: sata_pkg::CYC_W];
         fwd_row_ff <= wr_row;
      end
      if (s1_fire) begin
         rsp_hit_ff <= hit;
         rsp_way_ff <= sel_way_ext[sata_pkg::WAY_OUT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {{(sata_pkg::RSP_DATA_W - sata_pkg::WAY_OUT_W){1'b0}}, rsp_way_ff};

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // A refill leaves the refilled line valid and recorded as last refill.
   a_refill_valid: assert property (@(posedge clock) disable iff (reset)
      s1_fire && !hit |=> refill_seen_ff && valid_ff[last_set_ff][last_way_ff])
      else $error("refilled line not valid after a miss");

   // Refills only ever happen on a miss, so at most one way can match.
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $countones(match) <= 1)
      else $error("more than one way matches the tag");

   // A finished lookup always lands in the output register.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("lookup completed without a result");

   // An empty lookup stage never refuses an access.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("request refused with an empty lookup stage");

endmodule

// File: src/sata_tag_ram.sv
// ----------------------------------------------------------------------------
// sata_tag_ram: tag memory of the directory
// One row per set holds the tags of all ways; one registered read port and
// one write port. Contents are undefined until written.
// ----------------------------------------------------------------------------
module sata_tag_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 84
) (
   input  logic                                    clock,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // The read returns the row as it stood before a write at the same edge.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
